// ===== hdl/waypoint_follow_controller_macros.svh =====
// Assertion macros shared by the waypoint follower RTL
`ifndef WAYPOINT_FOLLOW_CONTROLLER_MACROS_SVH
`define WAYPOINT_FOLLOW_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WFC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define WFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define WFC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WFC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/wfc_pkg.sv =====
// Shared types, constants and tables of the waypoint follower
package wfc_pkg;

   localparam int MAX_POINTS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int GAIN_BITS      = 16;
   localparam int ANG_BITS       = 30;
   localparam int CORDIC_ITERS   = 24;
   localparam int SQ_STEPS       = 6;
   localparam int SQRT_STEPS     = 33;
   localparam int NORM_MSB       = 40;
   localparam int CW             = 44;
   localparam int ZW             = 34;
   localparam int CFG_W          = 31;
   localparam int CFG_IDX_W      = 3;
   localparam logic [ZW-1:0] PI_Q30 = 34'd3373259426;

   localparam logic [30:0] ARRIVE_RADIUS_RST = 31'd6554;
   localparam logic [16:0] SPEED_GAIN_RST    = 17'd13107;
   localparam logic [16:0] TURN_GAIN_RST     = 17'd6554;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_ENABLE        = 3'd0,
      REG_ARRIVE_RADIUS = 3'd1,
      REG_PATH_LENGTH   = 3'd2,
      REG_SPEED_GAIN    = 3'd3,
      REG_TURN_GAIN     = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_DRIVE    = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_DISABLED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_WRITE, DP_LOAD, DP_READ, DP_DIFF, DP_SQ, DP_SQRT,
      DP_NORM, DP_CORDIC, DP_ANG, DP_CMD
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [5:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic        dist_lt;
      logic        norm_done;
      logic [30:0] lin;
      logic [31:0] ang;
   } dp_stat_type;

   typedef struct packed {
      logic        enable;
      logic [30:0] arrive_radius;
      logic [4:0]  path_length;
      logic [16:0] speed_gain;
      logic [16:0] turn_gain;
   } cfg_type;

   // floored Q30 arctangent of 2^-i
   function automatic logic [30:0] atan_q30(input logic [4:0] i);
      logic [30:0] v;
      case (i)
         5'd0:  v = 31'h3243F6A8;
         5'd1:  v = 31'h1DAC6705;
         5'd2:  v = 31'h0FADBAFC;
         5'd3:  v = 31'h07F56EA6;
         5'd4:  v = 31'h03FEAB76;
         5'd5:  v = 31'h01FFD55B;
         5'd6:  v = 31'h00FFFAAA;
         5'd7:  v = 31'h007FFF55;
         5'd8:  v = 31'h003FFFEA;
         5'd9:  v = 31'h001FFFFD;
         5'd10: v = 31'h000FFFFF;
         5'd11: v = 31'h0007FFFF;
         5'd12: v = 31'h0003FFFF;
         5'd13: v = 31'h0001FFFF;
         5'd14: v = 31'h0000FFFF;
         5'd15: v = 31'h00007FFF;
         5'd16: v = 31'h00003FFF;
         5'd17: v = 31'h00001FFF;
         5'd18: v = 31'h00000FFF;
         5'd19: v = 31'h000007FF;
         5'd20: v = 31'h000003FF;
         5'd21: v = 31'h000001FF;
         5'd22: v = 31'h000000FF;
         5'd23: v = 31'h0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/wfc_req_if.sv =====
// Request channel: pose samples and waypoint table writes
interface wfc_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic [3:0]         point_slot;
   modport source (output valid, kind, coord_x, coord_y, point_slot, input ready);
   modport sink   (input valid, kind, coord_x, coord_y, point_slot, output ready);
endinterface

// ===== hdl/wfc_rsp_if.sv =====
// Response channel: status and motion commands
interface wfc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [30:0]        linear_cmd;
   logic signed [31:0] angular_cmd;
   logic [3:0]         target_slot;
   modport source (output valid, status, linear_cmd, angular_cmd, target_slot, input ready);
   modport sink   (input valid, status, linear_cmd, angular_cmd, target_slot, output ready);
endinterface

// ===== hdl/wfc_cfg.sv =====
// Configuration register file of the waypoint follower
module wfc_cfg
   import wfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfg_type              cfg,
   output logic                 restart
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.arrive_radius <= ARRIVE_RADIUS_RST;
         cfg_ff.path_length   <= 5'd0;
         cfg_ff.speed_gain    <= SPEED_GAIN_RST;
         cfg_ff.turn_gain     <= TURN_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENABLE:        cfg_ff.enable        <= csr_wdata[0];
            REG_ARRIVE_RADIUS: cfg_ff.arrive_radius <= csr_wdata[30:0];
            REG_PATH_LENGTH:   cfg_ff.path_length   <= csr_wdata[4:0];
            REG_SPEED_GAIN:    cfg_ff.speed_gain    <= csr_wdata[16:0];
            REG_TURN_GAIN:     cfg_ff.turn_gain     <= csr_wdata[16:0];
            default:           cfg_ff.enable        <= cfg_ff.enable;
         endcase
      end
   end

   assign cfg     = cfg_ff;
   // a new path length restarts the path at its first waypoint
   assign restart = csr_we && (csr_index == REG_PATH_LENGTH);

endmodule

// ===== hdl/wfc_dp.sv =====
// Datapath: waypoint table, distance square root, CORDIC heading, gains
module wfc_dp
   import wfc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  dp_cmd_type                          cmd,
   input  logic [$clog2(MAX_POINTS+1)-1:0]     tgt_idx,
   input  logic signed [31:0]                  in_x,
   input  logic signed [31:0]                  in_y,
   input  logic [3:0]                          in_slot,
   input  cfg_type                             cfg,
   output dp_stat_type                         stat
);

   localparam int IW = $clog2(MAX_POINTS+1);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int MW = FRAC_BITS + 3;
   localparam int PW = MW + 17;
   localparam int RS = ANG_BITS - FRAC_BITS;

   logic signed [31:0] mem_x [MAX_POINTS];
   logic signed [31:0] mem_y [MAX_POINTS];

   logic signed [31:0] rdx_ff, rdy_ff, px_ff, py_ff;
   logic [32:0]        ax_ff, ay_ff;
   logic               dxneg_ff, dyneg_ff, zero_ff, angneg_ff;
   logic [65:0]        acc_ff;
   logic [34:0]        rem_ff;
   logic [32:0]        root_ff;
   logic signed [CW-1:0] nx_ff, ny_ff;
   logic signed [ZW-1:0] z_ff;
   logic [MW-1:0]      mag_ff;
   logic [49:0]        linp_ff;
   logic [PW-1:0]      angp_ff;

   logic               slot_ok;
   logic [AW-1:0]      waddr, raddr;
   logic signed [32:0] dx, dy;
   logic [32:0]        sq_v;
   logic [16:0]        mul_a;
   logic [33:0]        mul_p;
   logic [65:0]        sq_term;
   logic [36:0]        rem_sh, trial;
   logic [4:0]         ci;
   logic signed [CW-1:0] xs, ys;
   logic signed [ZW-1:0] at, a_pre, a_sgn, a_abs, a_rnd;
   logic [49:0]        lin_w;
   logic [PW-1:0]      am_w;
   logic [30:0]        am31;
   logic [31:0]        am32;

   assign slot_ok = 32'(in_slot) < MAX_POINTS;
   assign waddr   = AW'(32'(in_slot));
   assign raddr   = AW'(tgt_idx);

   always_ff @(posedge clock) begin
      if (cmd.op == DP_WRITE && slot_ok) begin
         mem_x[waddr] <= in_x;
         mem_y[waddr] <= in_y;
      end
      if (cmd.op == DP_LOAD || cmd.op == DP_READ) begin
         rdx_ff <= mem_x[raddr];
         rdy_ff <= mem_y[raddr];
      end
   end

   always_comb begin
      dx  = 33'(rdx_ff) - 33'(px_ff);
      dy  = 33'(rdy_ff) - 33'(py_ff);
      sq_v = (cmd.step < 6'd3) ? ax_ff : ay_ff;
      case (cmd.step)
         6'd1, 6'd4: mul_a = {1'b0, sq_v[32:17]};
         6'd2, 6'd5: mul_a = {1'b0, sq_v[32:17]};
         default:    mul_a = sq_v[16:0];
      endcase
      case (cmd.step)
         6'd1, 6'd4: mul_p = mul_a * sq_v[16:0];
         default:    mul_p = mul_a * mul_a;
      endcase
      // partial products of the square: low*low, 2*low*high, high*high
      case (cmd.step)
         6'd1, 6'd4: sq_term = 66'(mul_p) << 18;
         6'd2, 6'd5: sq_term = 66'(mul_p) << 34;
         default:    sq_term = 66'(mul_p);
      endcase
      rem_sh = {rem_ff, acc_ff[65:64]};
      trial  = {2'b00, root_ff, 2'b01};
      ci     = cmd.step[4:0];
      xs     = nx_ff >>> ci;
      ys     = ny_ff >>> ci;
      at     = $signed({3'b000, atan_q30(ci)});
      a_pre  = dxneg_ff ? ($signed(PI_Q30) - z_ff) : z_ff;
      a_sgn  = dyneg_ff ? -a_pre : a_pre;
      a_abs  = a_sgn[ZW-1] ? -a_sgn : a_sgn;
      a_rnd  = a_abs + (ZW'(1) << (RS - 1));
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LOAD: begin
            px_ff <= in_x;
            py_ff <= in_y;
         end
         DP_DIFF: begin
            ax_ff    <= dx[32] ? 33'(-dx) : 33'(dx);
            ay_ff    <= dy[32] ? 33'(-dy) : 33'(dy);
            dxneg_ff <= dx[32];
            dyneg_ff <= dy[32];
            zero_ff  <= (dx == 33'sd0) && (dy == 33'sd0);
            nx_ff    <= $signed(CW'(dx[32] ? 33'(-dx) : 33'(dx)));
            ny_ff    <= $signed(CW'(dy[32] ? 33'(-dy) : 33'(dy)));
            z_ff     <= '0;
            acc_ff   <= '0;
            rem_ff   <= '0;
            root_ff  <= '0;
         end
         DP_SQ: acc_ff <= acc_ff + sq_term;
         DP_SQRT: begin
            acc_ff <= acc_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= 35'(rem_sh - trial);
               root_ff <= {root_ff[31:0], 1'b1};
            end else begin
               rem_ff  <= 35'(rem_sh);
               root_ff <= {root_ff[31:0], 1'b0};
            end
         end
         DP_NORM: begin
            nx_ff <= nx_ff <<< 1;
            ny_ff <= ny_ff <<< 1;
         end
         DP_CORDIC: begin
            if (ny_ff > 0) begin
               nx_ff <= nx_ff + ys;
               ny_ff <= ny_ff - xs;
               z_ff  <= z_ff + at;
            end else begin
               nx_ff <= nx_ff - ys;
               ny_ff <= ny_ff + xs;
               z_ff  <= z_ff - at;
            end
         end
         DP_ANG: begin
            mag_ff    <= zero_ff ? '0 : MW'(a_rnd >> RS);
            angneg_ff <= !zero_ff && a_sgn[ZW-1];
         end
         DP_CMD: begin
            linp_ff <= root_ff * cfg.speed_gain;
            angp_ff <= mag_ff * cfg.turn_gain;
         end
         default: acc_ff <= acc_ff;
      endcase
   end

   always_comb begin
      lin_w = linp_ff >> GAIN_BITS;
      am_w  = angp_ff >> GAIN_BITS;
      am31  = (64'(am_w) > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(am_w);
      am32  = {1'b0, am31};
      stat.dist_lt   = {2'b00, cfg.arrive_radius} > root_ff;
      stat.norm_done = zero_ff || (nx_ff[CW-1:NORM_MSB] != '0) ||
                       (ny_ff[CW-1:NORM_MSB] != '0);
      stat.lin       = (lin_w > 50'h7FFF_FFFF) ? 31'h7FFF_FFFF : lin_w[30:0];
      stat.ang       = angneg_ff ? (32'd0 - am32) : am32;
   end

endmodule

// ===== hdl/wfc_ctrl.sv =====
// Sequencer: item decode, path progress and response register
module wfc_ctrl
   import wfc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_kind,
   output logic                            req_ready,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output status_type                      rsp_status,
   output logic [3:0]                      rsp_slot,
   output logic [30:0]                     rsp_lin,
   output logic [31:0]                     rsp_ang,
   input  cfg_type                         cfg,
   input  logic                            restart,
   output dp_cmd_type                      cmd,
   output logic [$clog2(MAX_POINTS+1)-1:0] tgt_idx,
   input  dp_stat_type                     stat
);

   localparam int IW = $clog2(MAX_POINTS+1);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_DIFF, S_SQ, S_SQRT, S_CHECK, S_NORM, S_CORDIC,
      S_ANG, S_CMD, S_EMIT
   } state_type;

   state_type   state_ff;
   logic [5:0]  step_ff;
   logic [IW-1:0] tgt_ff;
   logic        fin_ff, pass2_ff, ov_ff;
   status_type  status_ff, ost_ff;
   logic [3:0]  oslot_ff;
   logic [30:0] olin_ff;
   logic [31:0] oang_ff;

   logic [IW-1:0] len, tgt_plus, slot_in;

   always_comb begin
      len      = (32'(cfg.path_length) < MAX_POINTS) ? IW'(cfg.path_length)
                                                     : IW'(MAX_POINTS);
      tgt_plus = tgt_ff + IW'(1);
      if (len == '0)
         slot_in = '0;
      else if (tgt_ff < len)
         slot_in = tgt_ff;
      else
         slot_in = len - IW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= '0;
         tgt_ff    <= '0;
         fin_ff    <= 1'b0;
         pass2_ff  <= 1'b0;
         ov_ff     <= 1'b0;
         status_ff <= ST_DRIVE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_kind) begin
                  pass2_ff <= 1'b0;
                  if (!cfg.enable) begin
                     status_ff <= ST_DISABLED;
                     state_ff  <= S_EMIT;
                  end else if (len == '0) begin
                     status_ff <= ST_EMPTY;
                     state_ff  <= S_EMIT;
                  end else if (fin_ff || tgt_ff >= len) begin
                     status_ff <= ST_COMPLETE;
                     state_ff  <= S_EMIT;
                  end else begin
                     state_ff <= S_DIFF;
                  end
               end
            end
            S_READ: state_ff <= S_DIFF;
            S_DIFF: begin
               step_ff  <= '0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               if (step_ff == 6'(SQ_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  step_ff <= step_ff + 6'd1;
               end
            end
            S_SQRT: begin
               if (step_ff == 6'(SQRT_STEPS - 1))
                  state_ff <= S_CHECK;
               else
                  step_ff <= step_ff + 6'd1;
            end
            S_CHECK: begin
               // arrival: advance, then aim at the next waypoint without a second check
               if (!pass2_ff && stat.dist_lt) begin
                  tgt_ff <= tgt_plus;
                  if (tgt_plus >= len) begin
                     fin_ff    <= 1'b1;
                     status_ff <= ST_COMPLETE;
                     state_ff  <= S_EMIT;
                  end else begin
                     pass2_ff <= 1'b1;
                     state_ff <= S_READ;
                  end
               end else begin
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (stat.norm_done) begin
                  step_ff  <= '0;
                  state_ff <= S_CORDIC;
               end
            end
            S_CORDIC: begin
               if (step_ff == 6'(CORDIC_ITERS - 1))
                  state_ff <= S_ANG;
               else
                  step_ff <= step_ff + 6'd1;
            end
            S_ANG: state_ff <= S_CMD;
            S_CMD: begin
               status_ff <= ST_DRIVE;
               state_ff  <= S_EMIT;
            end
            S_EMIT: begin
               // hold until the response register is free
               if (!ov_ff || rsp_ready) begin
                  ost_ff   <= status_ff;
                  oslot_ff <= 4'(slot_in);
                  olin_ff  <= (status_ff == ST_DRIVE) ? stat.lin : '0;
                  oang_ff  <= (status_ff == ST_DRIVE) ? stat.ang : '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // load a new beat into the response register, or drop the one taken
         if (state_ff == S_EMIT && (!ov_ff || rsp_ready))
            ov_ff <= 1'b1;
         else if (rsp_ready)
            ov_ff <= 1'b0;
         if (restart) begin
            tgt_ff <= '0;
            fin_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      cmd.op   = DP_NOP;
      cmd.step = step_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) cmd.op = req_kind ? DP_WRITE : DP_LOAD;
         S_READ:   cmd.op = DP_READ;
         S_DIFF:   cmd.op = DP_DIFF;
         S_SQ:     cmd.op = DP_SQ;
         S_SQRT:   cmd.op = DP_SQRT;
         S_NORM:   cmd.op = stat.norm_done ? DP_NOP : DP_NORM;
         S_CORDIC: cmd.op = DP_CORDIC;
         S_ANG:    cmd.op = DP_ANG;
         S_CMD:    cmd.op = DP_CMD;
         default:  cmd.op = DP_NOP;
      endcase
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign tgt_idx    = tgt_ff;
   assign rsp_valid  = ov_ff;
   assign rsp_status = ost_ff;
   assign rsp_slot   = oslot_ff;
   assign rsp_lin    = olin_ff;
   assign rsp_ang    = oang_ff;

endmodule

// ===== hdl/waypoint_follow_controller.sv =====
// Top level of the waypoint-following proportional controller
// Waypoints are loaded with req beats of kind 1, one per cycle while the sequencer
// is idle. A pose beat that only reports status (disabled, empty path, path
// complete) goes straight to the emit state, which loads the response register
// once it is free. A driving pose runs the distance, then a normalization shift
// loop (up to 40 shifts) ahead of the CORDIC, and a second distance pass when the
// current waypoint is reached and the next one is measured. The work is done by the
// 6-step shared 17x17 square unit, the 33-step bit-serial square root and the
// 24-iteration CORDIC, all run in turn by one sequencer; a new beat is taken once
// the response sits in its output register.
`include "waypoint_follow_controller_macros.svh"
module waypoint_follow_controller
   import wfc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   wfc_req_if.sink              req_if,
   wfc_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int IW = $clog2(MAX_POINTS+1);

   cfg_type     cfg;
   logic        restart;
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [IW-1:0] tgt_idx;
   status_type  rsp_status;

   wfc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .restart   (restart)
   );

   wfc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_kind   (req_if.kind),
      .req_ready  (req_if.ready),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_if.target_slot),
      .rsp_lin    (rsp_if.linear_cmd),
      .rsp_ang    (rsp_if.angular_cmd),
      .cfg        (cfg),
      .restart    (restart),
      .cmd        (cmd),
      .tgt_idx    (tgt_idx),
      .stat       (stat)
   );

   wfc_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .tgt_idx (tgt_idx),
      .in_x    (req_if.coord_x),
      .in_y    (req_if.coord_y),
      .in_slot (req_if.point_slot),
      .cfg     (cfg),
      .stat    (stat)
   );

   assign rsp_if.status = rsp_status;

   `WFC_ASSERT_IMP(a_idle_cmds_zero, clock, reset, rsp_if.valid && rsp_if.status != ST_DRIVE, rsp_if.linear_cmd == 31'd0 && rsp_if.angular_cmd == 32'sd0)
   `WFC_ASSERT_IMP(a_empty_slot_zero, clock, reset, rsp_if.valid && rsp_if.status == ST_EMPTY, rsp_if.target_slot == 4'd0)
   `WFC_ASSERT_NEXT(a_pose_busy, clock, reset, req_if.valid && req_if.ready && !req_if.kind, !req_if.ready)

endmodule

// ===== dv/tb_waypoint_follow_controller.sv =====
// Testbench of the waypoint follower: directed table, random traffic, scoreboard
module tb_waypoint_follow_controller;
   import wfc_pkg::*;

   localparam int       NPTS        = 16;
   localparam int       SEG_ITEMS   = 114;
   localparam int       SETTLE      = 200;
   localparam longint   CYCLE_LIMIT = 3000000;
   localparam longint   PI_Q30_L    = 64'sd3373259426;
   localparam logic signed [31:0] C_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] C_MIN = 32'sh80000000;
   localparam longint   ATAN_TAB [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   typedef struct {
      status_type         status;
      logic [30:0]        lin;
      logic signed [31:0] ang;
      logic [3:0]         slot;
   } cmd_t;

   typedef struct {
      bit                 is_reg;
      reg_index_type      idx;
      logic [30:0]        val;
      logic               kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [3:0]         slot;
      bit                 typed;
      cmd_t               want;
   } row_t;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   wfc_req_if req_if();
   wfc_rsp_if rsp_if();

   waypoint_follow_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // tracker shadow state
   logic signed [31:0] wp_x [NPTS];
   logic signed [31:0] wp_y [NPTS];
   int          tgt_idx;
   bit          path_done;
   bit          trk_enable;
   logic [30:0] trk_radius;
   logic [4:0]  trk_len;
   logic [16:0] trk_speed_gain;
   logic [16:0] trk_turn_gain;

   cmd_t   cmd_q[$];
   row_t   rows[$];
   int     errors;
   int     send_idle_pct;
   int     recv_idle_pct;
   int     hold_left;
   longint cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic logic [33:0] isqrt66(input logic [65:0] v);
      logic [33:0] root;
      logic [67:0] rem;
      logic [67:0] trial;
      root = '0;
      rem  = '0;
      for (int i = 32; i >= 0; i--) begin
         rem   = (rem << 2) | v[2*i +: 2];
         trial = {root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[32:0], 1'b1};
         end else begin
            root = {root[32:0], 1'b0};
         end
      end
      return root;
   endfunction

   function automatic logic [63:0] path_dist(input longint dx, input longint dy);
      logic [65:0] ax;
      logic [65:0] ay;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      return isqrt66(ax * ax + ay * ay);
   endfunction

   // atan2(dy, dx) in Q16 radians by vectoring CORDIC
   function automatic longint bearing_q16(input longint dx, input longint dy);
      longint ax, ay, m, x, y, z, xs, ys, a;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax == 0 && ay == 0) return 0;
      m = (ax > ay) ? ax : ay;
      while (m < (64'sd1 << 40)) begin
         ax = ax <<< 1;
         ay = ay <<< 1;
         m  = m <<< 1;
      end
      x = ax;
      y = ay;
      z = 0;
      for (int i = 0; i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_TAB[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_TAB[i];
         end
      end
      a = (dx < 0) ? PI_Q30_L - z : z;
      if (dy < 0) a = -a;
      m = (a < 0) ? -a : a;
      m = (m + (64'sd1 <<< 13)) >>> 14;
      return (a < 0) ? -m : m;
   endfunction

   task automatic track_step(input logic kind, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic [3:0] slot,
                             output bit produced, output cmd_t r);
      int          len;
      longint      dx, dy, h;
      logic [63:0] d, p, am;
      len      = (trk_len < NPTS) ? trk_len : NPTS;
      r.status = ST_DRIVE;
      r.lin    = '0;
      r.ang    = '0;
      produced = 1'b0;
      if (kind) begin
         wp_x[slot] = px;
         wp_y[slot] = py;
      end else begin
         produced = 1'b1;
         if (!trk_enable) begin
            r.status = ST_DISABLED;
         end else if (len == 0) begin
            r.status = ST_EMPTY;
         end else if (path_done || tgt_idx >= len) begin
            r.status = ST_COMPLETE;
         end else begin
            dx = longint'(wp_x[tgt_idx]) - longint'(px);
            dy = longint'(wp_y[tgt_idx]) - longint'(py);
            if (path_dist(dx, dy) < {33'd0, trk_radius}) begin
               tgt_idx++;
               if (tgt_idx >= len) path_done = 1'b1;
            end
            if (path_done) begin
               r.status = ST_COMPLETE;
            end else begin
               // aim at the new target without a second arrival check
               dx = longint'(wp_x[tgt_idx]) - longint'(px);
               dy = longint'(wp_y[tgt_idx]) - longint'(py);
               d  = path_dist(dx, dy);
               p  = (d * trk_speed_gain) >> 16;
               r.lin = (p > 64'h7FFFFFFF) ? 31'h7FFFFFFF : p[30:0];
               h  = bearing_q16(dx, dy);
               am = (((h < 0) ? -h : h) * trk_turn_gain) >> 16;
               if (am > 64'h7FFFFFFF) am = 64'h7FFFFFFF;
               r.ang = (h < 0) ? -am[31:0] : am[31:0];
            end
         end
         if (len == 0) r.slot = '0;
         else r.slot = (tgt_idx < len) ? tgt_idx[3:0] : 4'(len - 1);
      end
   endtask

   task automatic field_diff(input string name, input longint want, input longint got);
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
   endtask

   always @(posedge clock) begin
      cmd_t w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (cmd_q.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: expected none actual status %0d", $time,
                     rsp_if.status);
         end else begin
            w = cmd_q.pop_front();
            if (rsp_if.status !== w.status) field_diff("status", w.status, rsp_if.status);
            if (rsp_if.linear_cmd !== w.lin) field_diff("linear_cmd", w.lin, rsp_if.linear_cmd);
            if (rsp_if.angular_cmd !== w.ang)
               field_diff("angular_cmd", w.ang, rsp_if.angular_cmd);
            if (rsp_if.target_slot !== w.slot)
               field_diff("target_slot", w.slot, rsp_if.target_slot);
         end
      end
   end

   task automatic send_beat(input logic kind, input logic signed [31:0] x,
                            input logic signed [31:0] y, input logic [3:0] slot,
                            input bit typed, input cmd_t want);
      bit   produced;
      cmd_t r;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.kind       = kind;
      req_if.coord_x    = x;
      req_if.coord_y    = y;
      req_if.point_slot = slot;
      do @(posedge clock); while (!req_if.ready);
      track_step(kind, x, y, slot, produced, r);
      if (produced) cmd_q.insert(cmd_q.size(), typed ? want : r);
   endtask

   // drop valid, then wait out every pending response and the tail latency
   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (cmd_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [30:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         REG_ENABLE:        trk_enable = val[0];
         REG_ARRIVE_RADIUS: trk_radius = val;
         REG_PATH_LENGTH: begin
            trk_len   = val[4:0];
            tgt_idx   = 0;
            path_done = 1'b0;
         end
         REG_SPEED_GAIN:    trk_speed_gain = val[16:0];
         REG_TURN_GAIN:     trk_turn_gain  = val[16:0];
         default: ;
      endcase
   endtask

   function automatic row_t blank_row();
      row_t w;
      w.is_reg = 1'b0;
      w.idx    = REG_ENABLE;
      w.val    = '0;
      w.kind   = 1'b0;
      w.x      = '0;
      w.y      = '0;
      w.slot   = '0;
      w.typed  = 1'b0;
      w.want   = '{ST_DRIVE, '0, '0, '0};
      return w;
   endfunction

   function automatic void add_reg(input reg_index_type idx, input logic [30:0] val);
      row_t w;
      w = blank_row();
      w.is_reg = 1'b1;
      w.idx    = idx;
      w.val    = val;
      rows.insert(rows.size(), w);
   endfunction

   function automatic void add_beat(input logic kind, input logic signed [31:0] x,
                                    input logic signed [31:0] y, input logic [3:0] slot);
      row_t w;
      w = blank_row();
      w.kind = kind;
      w.x    = x;
      w.y    = y;
      w.slot = slot;
      rows.insert(rows.size(), w);
   endfunction

   function automatic void add_pose_want(input logic signed [31:0] x,
                                         input logic signed [31:0] y,
                                         input status_type st, input logic [3:0] slot);
      row_t w;
      w = blank_row();
      w.x           = x;
      w.y           = y;
      w.typed       = 1'b1;
      w.want.status = st;
      w.want.lin    = '0;
      w.want.ang    = '0;
      w.want.slot   = slot;
      rows.insert(rows.size(), w);
   endfunction

   function automatic logic signed [31:0] near_coord();
      return int'($urandom_range(0, 2097152)) - 1048576;
   endfunction

   task automatic random_setup();
      logic [30:0] radius;
      drain();
      write_reg(REG_ENABLE, 31'($urandom_range(0, 9) != 0));
      case ($urandom_range(0, 5))
         0:       radius = '0;
         1:       radius = 31'h7FFFFFFF;
         2:       radius = ARRIVE_RADIUS_RST;
         default: radius = 31'($urandom_range(1000, 300000));
      endcase
      write_reg(REG_ARRIVE_RADIUS, radius);
      case ($urandom_range(0, 3))
         0:       write_reg(REG_SPEED_GAIN, 31'd0);
         1:       write_reg(REG_SPEED_GAIN, 31'd65536);
         default: write_reg(REG_SPEED_GAIN, 31'($urandom_range(0, 65536)));
      endcase
      case ($urandom_range(0, 3))
         0:       write_reg(REG_TURN_GAIN, 31'd0);
         1:       write_reg(REG_TURN_GAIN, 31'd65536);
         default: write_reg(REG_TURN_GAIN, 31'($urandom_range(0, 65536)));
      endcase
      write_reg(REG_PATH_LENGTH,
                ($urandom_range(0, 9) == 0) ? 31'd0 : 31'($urandom_range(1, 20)));
   endtask

   task automatic random_segment(input int n, input int hold);
      int                 pick, lim, len;
      logic signed [31:0] x, y;
      cmd_t               none;
      none = '{ST_DRIVE, '0, '0, '0};
      random_setup();
      // stall the result side while the sender keeps offering beats
      if (hold > 0) hold_left = hold;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         len  = (trk_len < NPTS) ? trk_len : NPTS;
         if (pick < 12) begin
            if ($urandom_range(0, 3) == 0) begin
               x = $urandom;
               y = $urandom;
            end else begin
               x = near_coord();
               y = near_coord();
            end
            send_beat(1'b1, x, y, 4'($urandom_range(0, 15)), 1'b0, none);
         end else begin
            if (pick < 72 && trk_enable && tgt_idx < len) begin
               // land close to the target so arrivals happen often
               lim = (trk_radius > 40000) ? 40000 : trk_radius;
               x = wp_x[tgt_idx] + (int'($urandom_range(0, 2 * lim)) - lim);
               y = wp_y[tgt_idx] + (int'($urandom_range(0, 2 * lim)) - lim);
            end else if (pick < 88) begin
               x = near_coord();
               y = near_coord();
            end else begin
               x = $urandom;
               y = $urandom;
            end
            send_beat(1'b0, x, y, 4'($urandom_range(0, 15)), 1'b0, none);
         end
      end
   endtask

   initial begin
      row_t w;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.kind       = 1'b0;
      req_if.coord_x    = '0;
      req_if.coord_y    = '0;
      req_if.point_slot = '0;
      rsp_if.ready      = 1'b0;
      errors            = 0;
      cycles            = 0;
      hold_left         = 0;
      send_idle_pct     = 21;
      recv_idle_pct     = 83;
      tgt_idx           = 0;
      path_done         = 1'b0;
      trk_enable        = 1'b0;
      trk_radius        = ARRIVE_RADIUS_RST;
      trk_len           = '0;
      trk_speed_gain    = SPEED_GAIN_RST;
      trk_turn_gain     = TURN_GAIN_RST;
      for (int s = 0; s < NPTS; s++) begin
         wp_x[s] = '0;
         wp_y[s] = '0;
      end

      add_pose_want(32'sd0, 32'sd0, ST_DISABLED, 4'd0);
      add_reg(REG_ENABLE, 31'd1);
      add_pose_want(C_MIN, C_MAX, ST_EMPTY, 4'd0);
      add_beat(1'b1, 32'sd0, 32'sd0, 4'd0);
      add_beat(1'b1, C_MAX, C_MAX, 4'd1);
      add_beat(1'b1, C_MIN, C_MIN, 4'd2);
      add_beat(1'b1, C_MAX, C_MIN, 4'd3);
      for (int s = 4; s < NPTS; s++) add_beat(1'b1, s * 65536, -s * 32768, 4'(s));
      // length above the table size counts as the full table
      add_reg(REG_PATH_LENGTH, 31'd31);
      add_beat(1'b0, 32'sd0, 32'sd0, 4'd9);
      add_beat(1'b0, C_MIN, C_MIN, 4'd0);
      add_reg(REG_PATH_LENGTH, 31'd1);
      add_pose_want(32'sd0, 32'sd0, ST_COMPLETE, 4'd0);
      add_pose_want(32'sd5, 32'sd5, ST_COMPLETE, 4'd0);
      add_reg(REG_SPEED_GAIN, 31'd65536);
      add_reg(REG_TURN_GAIN, 31'd65536);
      add_reg(REG_ARRIVE_RADIUS, 31'd0);
      add_reg(REG_PATH_LENGTH, 31'd4);
      add_beat(1'b0, C_MIN, C_MIN, 4'd0);
      add_beat(1'b0, C_MAX, C_MAX, 4'd0);
      add_beat(1'b0, C_MAX, C_MIN, 4'd0);
      add_reg(REG_ENABLE, 31'd0);
      add_pose_want(32'sd1, 32'sd1, ST_DISABLED, 4'd0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         w = rows[i];
         if (w.is_reg) begin
            drain();
            write_reg(w.idx, w.val);
         end else begin
            send_beat(w.kind, w.x, w.y, w.slot, w.typed, w.want);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 83 : 0;
         recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 21 : 0;
         for (int sg = 0; sg < 3; sg++) begin
            // in the first segment of the last phase, stall the result side for a long stretch to back up the input
            random_segment(SEG_ITEMS, (ph == 2 && sg == 0) ? 600 : 0);
         end
      end

      drain();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
